>>> src/vtu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vtu_pkg;

	localparam logic [3:0] OP_TRANSLATE = 4'd0;
	localparam logic [3:0] OP_SCALE_VEC = 4'd1;
	localparam logic [3:0] OP_SCALE_ALL = 4'd2;
	localparam logic [3:0] OP_SCALE_X   = 4'd3;
	localparam logic [3:0] OP_SCALE_Y   = 4'd4;
	localparam logic [3:0] OP_SCALE_Z   = 4'd5;
	localparam logic [3:0] OP_ROT_X     = 4'd6;
	localparam logic [3:0] OP_ROT_Y     = 4'd7;
	localparam logic [3:0] OP_ROT_Z     = 4'd8;

	// 1/K in Q30, radians-to-phase split into integer and Q32 fraction
	localparam logic signed [63:0] INV_GAIN_Q30  = 64'sd652032874;
	localparam logic signed [63:0] TURN_INT      = 64'sd10430;
	localparam logic signed [63:0] TURN_FRAC_Q32 = 64'sd1625002897;
	localparam logic signed [33:0] QUARTER       = 34'sd1073741824;

	// Residual angle width and datapath width of the rotator
	localparam int ANG_W = 34;
	localparam int ROT_W = 44;

	typedef struct packed {
		logic [3:0]         op;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [2:0]         flg;
	} side_t;

	function automatic logic [29:0] atan_turn(input int i);
		logic [29:0] r;
		case (i)
			0:  r = 30'd536870912;
			1:  r = 30'd316933406;
			2:  r = 30'd167458907;
			3:  r = 30'd85004756;
			4:  r = 30'd42667331;
			5:  r = 30'd21354465;
			6:  r = 30'd10679838;
			7:  r = 30'd5340245;
			8:  r = 30'd2670163;
			9:  r = 30'd1335087;
			10: r = 30'd667544;
			11: r = 30'd333772;
			12: r = 30'd166886;
			13: r = 30'd83443;
			14: r = 30'd41722;
			15: r = 30'd20861;
			16: r = 30'd10430;
			17: r = 30'd5215;
			18: r = 30'd2608;
			19: r = 30'd1304;
			20: r = 30'd652;
			21: r = 30'd326;
			22: r = 30'd163;
			23: r = 30'd81;
			24: r = 30'd41;
			25: r = 30'd20;
			26: r = 30'd10;
			27: r = 30'd5;
			28: r = 30'd3;
			29: r = 30'd1;
			30: r = 30'd1;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/vertex_transform_unit_top.sv
// Vertex transform unit: one vertex and one operation per transfer on the
// input channel (in_valid/in_ready), one transformed vertex per transfer on
// the output channel (out_valid/out_ready). Operations: translate, scale by
// vector, uniform scale, single-axis scale, rotate about X, Y or Z.
// Rotation runs a CORDIC with one pipeline stage per iteration.
// Stages from input transfer to out_valid: five front stages (products,
// rounding/phase, quadrant fold, prescale multiply, prescale round), then the
// CORDIC stages, then the output register.
// Throughput: one item per cycle unless the receiver stalls; every stage is a register with a valid bit.
// A receiver stall (out_ready low while out_valid) freezes the whole
// pipeline and drops in_ready in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
// Results saturate to a COORD_WIDTH-bit signed range (capped at 32 bits)
// and raise saturated when any coordinate was clamped.
`timescale 1ns / 1ps
`default_nettype none
module vertex_transform_unit_top import vtu_pkg::*; #(
	parameter int CORDIC_STEPS = 24,
	parameter int COORD_WIDTH  = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire  [3:0]         opcode,
	input  wire  signed [31:0] vert_x,
	input  wire  signed [31:0] vert_y,
	input  wire  signed [31:0] vert_z,
	input  wire  signed [31:0] vec_x,
	input  wire  signed [31:0] vec_y,
	input  wire  signed [31:0] vec_z,
	input  wire  signed [31:0] amount,
	output logic               out_valid,
	input  wire                out_ready,
	output logic signed [31:0] res_x,
	output logic signed [31:0] res_y,
	output logic signed [31:0] res_z,
	output logic               saturated
);

	localparam int SAT_BITS = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 2) ? 2 : COORD_WIDTH);
	localparam int STEPS    = (CORDIC_STEPS > 32) ? 32 : ((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);
	localparam logic signed [47:0] SAT_HI = (48'sd1 <<< (SAT_BITS - 1)) - 48'sd1;
	localparam logic signed [47:0] SAT_LO = -SAT_HI - 48'sd1;

	// {flag, value}
	function automatic logic [32:0] sat_coord(input logic signed [47:0] v);
		logic [32:0] r;
		if (v > SAT_HI) begin
			r = {1'b1, SAT_HI[31:0]};
		end else if (v < SAT_LO) begin
			r = {1'b1, SAT_LO[31:0]};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	logic advance;
	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;

	// ---------------- stage 1: products and sums ----------------
	logic               vld_s1;
	logic [3:0]         op_s1;
	logic signed [31:0] x_s1, y_s1, z_s1;
	logic signed [32:0] tx_s1, ty_s1, tz_s1;
	logic signed [63:0] mx_s1, my_s1, mz_s1;
	logic signed [63:0] pi_s1, pf_s1;

	logic signed [31:0] fx, fy, fz;
	always_comb begin
		fx = (opcode == OP_SCALE_VEC) ? vec_x : amount;
		fy = (opcode == OP_SCALE_VEC) ? vec_y : amount;
		fz = (opcode == OP_SCALE_VEC) ? vec_z : amount;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_s1 <= opcode;
			x_s1  <= vert_x;
			y_s1  <= vert_y;
			z_s1  <= vert_z;
			tx_s1 <= 33'(vert_x) + 33'(vec_x);
			ty_s1 <= 33'(vert_y) + 33'(vec_y);
			tz_s1 <= 33'(vert_z) + 33'(vec_z);
			mx_s1 <= 64'(vert_x) * 64'(fx);
			my_s1 <= 64'(vert_y) * 64'(fy);
			mz_s1 <= 64'(vert_z) * 64'(fz);
			pi_s1 <= 64'(amount) * TURN_INT;
			pf_s1 <= 64'(amount) * TURN_FRAC_Q32;
		end
	end

	// ---------------- stage 2: rounding, clamp, phase, plane select ----------------
	logic               vld_s2;
	side_t              side_s2;
	logic signed [31:0] u_s2, v_s2;
	logic [31:0]        ph_s2;

	logic signed [47:0] qx, qy, qz, nx, ny, nz;
	logic signed [63:0] rx, ry, rz, ptot;
	logic [32:0]        cx, cy, cz;
	logic [31:0]        ph;
	logic signed [31:0] pu, pv;
	always_comb begin
		rx = (mx_s1 + 64'sd32768) >>> 16;
		ry = (my_s1 + 64'sd32768) >>> 16;
		rz = (mz_s1 + 64'sd32768) >>> 16;
		qx = rx[47:0];
		qy = ry[47:0];
		qz = rz[47:0];
		nx = 48'(x_s1);
		ny = 48'(y_s1);
		nz = 48'(z_s1);
		case (op_s1)
			OP_TRANSLATE: begin
				nx = 48'(tx_s1);
				ny = 48'(ty_s1);
				nz = 48'(tz_s1);
			end
			OP_SCALE_VEC, OP_SCALE_ALL: begin
				nx = qx;
				ny = qy;
				nz = qz;
			end
			OP_SCALE_X: nx = qx;
			OP_SCALE_Y: ny = qy;
			OP_SCALE_Z: nz = qz;
			default: ;
		endcase
		cx = sat_coord(nx);
		cy = sat_coord(ny);
		cz = sat_coord(nz);

		ptot = pi_s1 + ((pf_s1 + 64'sd2147483648) >>> 32);
		ph   = ptot[31:0];
		if (op_s1 == OP_ROT_X || op_s1 == OP_ROT_Z) begin
			ph = 32'd0 - ph;
		end

		case (op_s1)
			OP_ROT_X: begin
				pu = z_s1;
				pv = y_s1;
			end
			OP_ROT_Y: begin
				pu = z_s1;
				pv = x_s1;
			end
			default: begin
				pu = x_s1;
				pv = y_s1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			side_s2.op  <= op_s1;
			side_s2.x   <= cx[31:0];
			side_s2.y   <= cy[31:0];
			side_s2.z   <= cz[31:0];
			side_s2.flg <= {cz[32], cy[32], cx[32]};
			u_s2        <= pu;
			v_s2        <= pv;
			ph_s2       <= ph;
		end
	end

	// ---------------- stage 3: quadrant fold ----------------
	logic                    vld_s3;
	side_t                   side_s3;
	logic signed [32:0]      u_s3, v_s3;
	logic signed [ANG_W-1:0] ang_s3;

	logic signed [ANG_W-1:0] a_in, a_fold;
	logic signed [32:0]      fu, fv;
	always_comb begin
		a_in   = ANG_W'($signed(ph_s2));
		a_fold = a_in;
		fu     = 33'(u_s2);
		fv     = 33'(v_s2);
		if (a_in > QUARTER) begin
			fu     = -33'(v_s2);
			fv     = 33'(u_s2);
			a_fold = a_in - QUARTER;
		end else if (a_in < -QUARTER) begin
			fu     = 33'(v_s2);
			fv     = -33'(u_s2);
			a_fold = a_in + QUARTER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (advance) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			side_s3 <= side_s2;
			u_s3    <= fu;
			v_s3    <= fv;
			ang_s3  <= a_fold;
		end
	end

	// ---------------- stage 4: gain prescale multiply ----------------
	logic                    vld_s4;
	side_t                   side_s4;
	logic signed [63:0]      pu_s4, pv_s4;
	logic signed [ANG_W-1:0] ang_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (advance) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			side_s4 <= side_s3;
			pu_s4   <= 64'(u_s3) * INV_GAIN_Q30;
			pv_s4   <= 64'(v_s3) * INV_GAIN_Q30;
			ang_s4  <= ang_s3;
		end
	end

	// ---------------- stage 5 and CORDIC stages ----------------
	// index 0 holds the prescaled vector, index k the vector after k iterations
	logic                    cord_vld_s  [0:STEPS];
	side_t                   cord_side_s [0:STEPS];
	logic signed [ROT_W-1:0] cord_x_s    [0:STEPS];
	logic signed [ROT_W-1:0] cord_y_s    [0:STEPS];
	logic signed [ANG_W-1:0] cord_a_s    [0:STEPS];

	logic signed [63:0] ru, rv;
	always_comb begin
		ru = (pu_s4 + 64'sd2097152) >>> 22;
		rv = (pv_s4 + 64'sd2097152) >>> 22;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cord_vld_s[0] <= 1'b0;
		end else if (advance) begin
			cord_vld_s[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cord_side_s[0] <= side_s4;
			cord_x_s[0]    <= ru[ROT_W-1:0];
			cord_y_s[0]    <= rv[ROT_W-1:0];
			cord_a_s[0]    <= ang_s4;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_cordic
		localparam logic signed [ANG_W-1:0] ATAN = ANG_W'(atan_turn(i));
		logic signed [ROT_W-1:0] dx, dy;
		assign dx = cord_y_s[i] >>> i;
		assign dy = cord_x_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cord_vld_s[i+1] <= 1'b0;
			end else if (advance) begin
				cord_vld_s[i+1] <= cord_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				cord_side_s[i+1] <= cord_side_s[i];
				if (!cord_a_s[i][ANG_W-1]) begin
					cord_x_s[i+1] <= cord_x_s[i] - dx;
					cord_y_s[i+1] <= cord_y_s[i] + dy;
					cord_a_s[i+1] <= cord_a_s[i] - ATAN;
				end else begin
					cord_x_s[i+1] <= cord_x_s[i] + dx;
					cord_y_s[i+1] <= cord_y_s[i] - dy;
					cord_a_s[i+1] <= cord_a_s[i] + ATAN;
				end
			end
		end
	end

	// ---------------- output stage ----------------
	logic signed [ROT_W-1:0] fxr, fyr;
	logic [32:0]             su, sv;
	logic signed [31:0]      ox, oy, oz;
	logic [2:0]              of;
	side_t                   sd;
	always_comb begin
		sd  = cord_side_s[STEPS];
		fxr = (cord_x_s[STEPS] + ROT_W'(128)) >>> 8;
		fyr = (cord_y_s[STEPS] + ROT_W'(128)) >>> 8;
		su  = sat_coord(48'(fxr));
		sv  = sat_coord(48'(fyr));
		ox  = sd.x;
		oy  = sd.y;
		oz  = sd.z;
		of  = sd.flg;
		case (sd.op)
			OP_ROT_X: begin
				oz = su[31:0];
				oy = sv[31:0];
				of = {su[32], sv[32], sd.flg[0]};
			end
			OP_ROT_Y: begin
				oz = su[31:0];
				ox = sv[31:0];
				of = {su[32], sd.flg[1], sv[32]};
			end
			OP_ROT_Z: begin
				ox = su[31:0];
				oy = sv[31:0];
				of = {sd.flg[2], sv[32], su[32]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= cord_vld_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_x     <= ox;
			res_y     <= oy;
			res_z     <= oz;
			saturated <= |of;
		end
	end

	// ---------------- assertions ----------------
	a_accept_enters : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s1)
		else $error("accepted item did not enter stage 1");

	a_stall_freezes : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(vld_s1) && $stable(cord_vld_s[0]))
		else $error("pipeline moved during output stall");

	a_sat_at_limit : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			res_x == SAT_HI[31:0] || res_x == SAT_LO[31:0] ||
			res_y == SAT_HI[31:0] || res_y == SAT_LO[31:0] ||
			res_z == SAT_HI[31:0] || res_z == SAT_LO[31:0])
		else $error("saturated flag without a clamped coordinate");

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench import vtu_pkg::*;;

	localparam int STEPS     = 24;
	localparam int CW        = 32;
	localparam int LATENCY   = STEPS + 6;
	localparam int N_RANDOM  = 1950;
	localparam int MAX_CYCLES = 400000;

	typedef struct {
		logic [31:0] x, y, z;
		logic        sat;
	} vertex_t;

	// Predicts the transformed vertex and keeps the results still owed.
	class transform_board;
		vertex_t pending[$];
		int errors;
		int checked;

		function longint fshift(longint v, int n);
			return v >>> n;
		endfunction

		function longint clampc(longint v, ref bit flag);
			longint hi, lo;
			hi = (64'sd1 <<< (CW - 1)) - 1;
			lo = -hi - 1;
			if (v > hi) begin
				flag = 1;
				return hi;
			end
			if (v < lo) begin
				flag = 1;
				return lo;
			end
			return v;
		endfunction

		function longint qmul(longint a, longint b);
			return fshift(a * b + 32768, 16);
		endfunction

		function logic [31:0] to_phase(longint a);
			longint p;
			p = a * TURN_INT + fshift(a * TURN_FRAC_Q32 + (64'sd1 <<< 31), 32);
			return p[31:0];
		endfunction

		function void turn_plane(ref longint u, ref longint v, input logic [31:0] ph);
			longint s, a, b, t, da, db;
			s = longint'(signed'(ph));
			a = u;
			b = v;
			if (s > QUARTER) begin
				t = a; a = -b; b = t; s -= QUARTER;
			end else if (s < -QUARTER) begin
				t = a; a = b; b = -t; s += QUARTER;
			end
			a = fshift(a * INV_GAIN_Q30 + (64'sd1 <<< 21), 22);
			b = fshift(b * INV_GAIN_Q30 + (64'sd1 <<< 21), 22);
			for (int i = 0; i < STEPS; i++) begin
				da = fshift(b, i);
				db = fshift(a, i);
				if (s >= 0) begin
					a -= da; b += db; s -= longint'(atan_turn(i));
				end else begin
					a += da; b -= db; s += longint'(atan_turn(i));
				end
			end
			u = fshift(a + 128, 8);
			v = fshift(b + 128, 8);
		endfunction

		function void note_input(logic [3:0] op, logic [31:0] ix, iy, iz,
				logic [31:0] jx, jy, jz, logic [31:0] am);
			longint x, y, z, vx, vy, vz, amt;
			bit flag;
			vertex_t r;
			x = signed'(ix); y = signed'(iy); z = signed'(iz);
			vx = signed'(jx); vy = signed'(jy); vz = signed'(jz);
			amt = signed'(am);
			flag = 0;
			case (op)
				OP_TRANSLATE: begin x += vx; y += vy; z += vz; end
				OP_SCALE_VEC: begin x = qmul(x, vx); y = qmul(y, vy); z = qmul(z, vz); end
				OP_SCALE_ALL: begin x = qmul(x, amt); y = qmul(y, amt); z = qmul(z, amt); end
				OP_SCALE_X: x = qmul(x, amt);
				OP_SCALE_Y: y = qmul(y, amt);
				OP_SCALE_Z: z = qmul(z, amt);
				OP_ROT_X: turn_plane(z, y, 32'd0 - to_phase(amt));
				OP_ROT_Y: turn_plane(z, x, to_phase(amt));
				OP_ROT_Z: turn_plane(x, y, 32'd0 - to_phase(amt));
				default: ;
			endcase
			x = clampc(x, flag);
			y = clampc(y, flag);
			z = clampc(z, flag);
			r.x = x[31:0]; r.y = y[31:0]; r.z = z[31:0]; r.sat = flag;
			pending.push_back(r);
		endfunction

		function void check_result(logic [31:0] rx, ry, rz, logic rs);
			vertex_t e;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h %h %h %b", rx, ry, rz, rs);
				return;
			end
			e = pending.pop_front();
			if (e.x !== rx || e.y !== ry || e.z !== rz || e.sat !== rs) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %h %h %h %b, got %h %h %h %b",
						e.x, e.y, e.z, e.sat, rx, ry, rz, rs);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [3:0] opcode = '0;
	logic signed [31:0] vert_x = '0, vert_y = '0, vert_z = '0;
	logic signed [31:0] vec_x = '0, vec_y = '0, vec_z = '0, amount = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [31:0] res_x, res_y, res_z;
	logic saturated;

	transform_board board;
	int cycles = 0;
	bit hold_off = 0;
	bit sending_done = 0;
	int sent = 0;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	vertex_transform_unit_top #(.CORDIC_STEPS(STEPS), .COORD_WIDTH(CW)) u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z), .amount(amount),
		.out_valid(out_valid), .out_ready(out_ready), .res_x(res_x), .res_y(res_y),
		.res_z(res_z), .saturated(saturated)
	);

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'd0;
			3: return signed'($urandom_range(0, 65536 * 4)) - 32'sd131072;
			4: return signed'($urandom_range(0, 1 << 24)) - 32'sd8388608;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_vertex(logic [3:0] op, logic [31:0] ix, iy, iz,
			logic [31:0] jx, jy, jz, logic [31:0] am, int gap);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		opcode <= op;
		vert_x <= ix; vert_y <= iy; vert_z <= iz;
		vec_x <= jx; vec_y <= jy; vec_z <= jz;
		amount <= am;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_input(op, ix, iy, iz, jx, jy, jz, am);
		sent++;
	endtask

	// Draw idle gap, with bursts of back-to-back transfers.
	function automatic int draw_gap();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
	endfunction

	initial begin
		logic [3:0] op;
		int gap;
		logic [31:0] amt;
		board = new();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: each op with extremes, zero radius, quarter/half turns, bad opcodes
		for (int o = 0; o <= 8; o++)
			send_vertex(o[3:0], 32'h7FFFFFFF, 32'h80000000, 32'h00010000,
				32'h7FFFFFFF, 32'h80000000, 32'hFFFF0000, 32'h00020000, 0);
		send_vertex(OP_ROT_X, 0, 0, 0, 0, 0, 0, 32'h00010000, 0);
		send_vertex(OP_ROT_Y, 32'h00010000, 0, 0, 0, 0, 0, 32'h0001921F, 1);
		send_vertex(OP_ROT_Z, 32'h00010000, 32'h00020000, 5, 0, 0, 0, 32'hFFFE6DE1, 0);
		send_vertex(OP_ROT_Z, 32'h80000000, 32'h80000000, 5, 0, 0, 0, 32'h00032440, 0);
		send_vertex(OP_ROT_X, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0,
			32'h80000000, 2);
		send_vertex(OP_ROT_Y, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0,
			32'h7FFFFFFF, 0);
		send_vertex(4'd9, 32'h80000000, 1, 2, 3, 4, 5, 6, 0);
		send_vertex(4'd15, 32'h7FFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0);
		send_vertex(OP_SCALE_ALL, 32'hFFFF8000, 32'h00008000, 1, 0, 0, 0, 32'h00008000, 0);
		for (int n = 0; n < N_RANDOM; n++) begin
			op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(0, 8));
			amt = ($urandom_range(0, 1)) ? pick_value()
				: signed'($urandom_range(0, 32'h000C9100)) - 32'sd411774;
			gap = (n > 600 && n < 700) ? 0 : draw_gap();
			send_vertex(op, pick_value(), pick_value(), pick_value(), pick_value(),
				pick_value(), pick_value(), amt, gap);
		end
		in_valid <= 0;
		sending_done = 1;
	end

	// Receiver: random stalls, plus one long hold-off to fill the pipeline.
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			if (sent > 620 && !hold_off) begin
				hold_off = 1;
				out_ready <= 0;
				repeat (200) @(posedge clk);
			end
			wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
			if (wait_n > 0) begin
				out_ready <= 0;
				repeat (wait_n) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			board.check_result(res_x, res_y, res_z, saturated);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		wait (sending_done);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		$display("Covered %0d vertices over all nine operations and unknown opcodes,",
			board.checked);
		$display("with extreme values, rotations in every quadrant and a long output stall.");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

>>> files.f
src/vtu_pkg.sv
src/vertex_transform_unit_top.sv
tb/sv/testbench.sv
